FILE: sv/tcpsw_pkg.sv
// ----------------------------------------------------------------------------
// tcpsw_pkg
// Shared types and constants for the stop-and-wait TCP endpoint.
// ----------------------------------------------------------------------------
package tcpsw_pkg;

  localparam int STORE_DEPTH = 8;
  localparam int SEQ_BITS    = 16;
  localparam int DATA_BITS   = 32;
  localparam int IDX_BITS    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int ENTRY_BITS  = SEQ_BITS + 16 + DATA_BITS;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RECV  = 3'd1;
  localparam logic [2:0] CMD_LISTN = 3'd2;
  localparam logic [2:0] CMD_CONN  = 3'd3;
  localparam logic [2:0] CMD_SEND  = 3'd4;
  localparam logic [2:0] CMD_DISC  = 3'd5;

  localparam logic [2:0] ST_CLOSED    = 3'd0;
  localparam logic [2:0] ST_LISTEN    = 3'd1;
  localparam logic [2:0] ST_SYN_SENT  = 3'd2;
  localparam logic [2:0] ST_SYN_RCVD  = 3'd3;
  localparam logic [2:0] ST_ESTAB     = 3'd4;
  localparam logic [2:0] ST_FIN_WAIT1 = 3'd5;
  localparam logic [2:0] ST_FIN_WAIT2 = 3'd6;
  localparam logic [2:0] ST_CLOSE_ACK = 3'd7;

  typedef struct packed {
    logic [7:0]           src;
    logic [7:0]           dst;
    logic                 syn;
    logic                 ack;
    logic                 fin;
    logic [SEQ_BITS-1:0]  seq;
    logic [DATA_BITS-1:0] data;
  } seg_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]  seq;
    logic [15:0]          route;
    logic [DATA_BITS-1:0] data;
  } entry_t;

endpackage

FILE: sv/tcpsw_ram.sv
// ----------------------------------------------------------------------------
// tcpsw_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcpsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/tcpsw_outq.sv
// ----------------------------------------------------------------------------
// tcpsw_outq
// Output register for result segments with a one-entry skid stage.
// ----------------------------------------------------------------------------
module tcpsw_outq
  import tcpsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  seg_t       push_seg,
  input  logic [2:0] push_status,
  input  logic       push_await,
  input  logic       push_last,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output seg_t       out_seg,
  output logic [2:0] out_status,
  output logic       out_await,
  output logic       out_last
);
  logic [1:0] cnt;
  seg_t       skid_seg;
  logic [2:0] skid_status;
  logic       skid_await;
  logic       skid_last;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt != 2'd0);
  assign full      = (cnt == 2'd2) || (cnt == 2'd1 && !pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      if (cnt == 2'd2) begin
        out_seg    <= skid_seg;
        out_status <= skid_status;
        out_await  <= skid_await;
        out_last   <= skid_last;
      end else if (push) begin
        out_seg    <= push_seg;
        out_status <= push_status;
        out_await  <= push_await;
        out_last   <= push_last;
      end
    end else if (push && cnt == 2'd0) begin
      out_seg    <= push_seg;
      out_status <= push_status;
      out_await  <= push_await;
      out_last   <= push_last;
    end
    if (push && (cnt == 2'd2 || (cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      skid_seg    <= push_seg;
      skid_status <= push_status;
      skid_await  <= push_await;
      skid_last   <= push_last;
    end
  end
endmodule

FILE: sv/tcpsw_ctrl.sv
// ----------------------------------------------------------------------------
// tcpsw_ctrl
// Connection sequencer: decodes one item, walks the retransmit store in RAM
// and pushes result segments.
// ----------------------------------------------------------------------------
module tcpsw_ctrl
  import tcpsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          timeout_ticks,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [7:0]           src_node,
  input  logic [7:0]           dst_node,
  input  logic                 pkt_syn,
  input  logic                 pkt_ack,
  input  logic                 pkt_fin,
  input  logic                 pkt_corrupted,
  input  logic [SEQ_BITS-1:0]  pkt_seq,
  input  logic [DATA_BITS-1:0] payload,
  output logic                 push,
  output seg_t                 push_seg,
  output logic [2:0]           push_status,
  output logic                 push_await,
  output logic                 push_last,
  input  logic                 q_full
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_EMIT  = 6'b001000,
    S_RTX   = 6'b010000,
    S_RTXE  = 6'b100000
  } state_t;

  state_t state;

  logic [2:0]           conn;
  logic [SEQ_BITS-1:0]  nss;
  logic [SEQ_BITS-1:0]  ers;
  logic                 ackp;
  logic [18:0]          ctl;
  logic [15:0]          tss;
  logic [STORE_DEPTH-1:0] vld;

  // latched item
  logic [2:0]           c_cmd;
  logic [7:0]           c_src, c_dst;
  logic                 c_syn, c_ack, c_fin, c_bad;
  logic [SEQ_BITS-1:0]  c_seq;
  logic [DATA_BITS-1:0] c_pay;

  // store scan, one RAM entry per cycle
  logic [IDX_BITS-1:0]  ridx;
  logic [IDX_BITS-1:0]  sidx;
  logic                 rd_ok;
  entry_t               rdata;
  logic [SEQ_BITS-1:0]  key;
  logic                 hit_f;
  logic [IDX_BITS-1:0]  hit_i;
  entry_t               hit_e;

  // retransmit pass
  logic                 first;
  logic [SEQ_BITS-1:0]  prev;
  logic                 best_f;
  entry_t               best_e;
  logic [CNT_BITS-1:0]  npass;
  logic [CNT_BITS-1:0]  vcnt;
  logic                 rtx_last;

  // pending output list (at most two from decode)
  seg_t                 ob [3];
  logic [1:0]           on;
  logic [1:0]           oi;

  logic                 we;
  logic [IDX_BITS-1:0]  waddr;
  entry_t               wdata;

  tcpsw_ram #(.WIDTH(ENTRY_BITS), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(ridx), .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE);

  function automatic seg_t ctl_seg(input logic [7:0] s, input logic [7:0] d,
                                   input logic sy, input logic ak, input logic fn);
    seg_t r;
    r.src = s; r.dst = d; r.syn = sy; r.ack = ak; r.fin = fn;
    r.seq = '0; r.data = '0;
    return r;
  endfunction

  function automatic seg_t data_seg(input entry_t e);
    seg_t r;
    r.src = e.route[15:8]; r.dst = e.route[7:0];
    r.syn = 1'b0; r.ack = 1'b0; r.fin = 1'b0;
    r.seq = e.seq; r.data = e.data;
    return r;
  endfunction

  logic [SEQ_BITS-1:0] nss_m1;
  logic [15:0]         tss_inc;
  logic                free_f;
  logic [IDX_BITS-1:0] free_i;
  logic                cand;

  assign nss_m1  = nss - 1'b1;
  assign tss_inc = (tss == 16'hFFFF) ? tss : tss + 16'd1;
  assign cand    = rd_ok && vld[sidx] && (first || rdata.seq > prev) &&
                   (!best_f || rdata.seq < best_e.seq);
  // stored sequences are distinct, so a burst resends every valid entry
  assign rtx_last = ((npass + CNT_BITS'(1)) == vcnt);

  always_comb begin
    free_f = 1'b0;
    free_i = '0;
    for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        free_f = 1'b1;
        free_i = IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    vcnt = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      vcnt = vcnt + CNT_BITS'(vld[i]);
    end
  end

  always_comb begin
    push        = 1'b0;
    push_seg    = ob[oi];
    push_status = conn;
    push_await  = ackp;
    push_last   = (oi == on - 2'd1);
    if (state == S_EMIT && on != 2'd0 && !q_full) begin
      push = 1'b1;
    end else if (state == S_RTXE && !q_full) begin
      push      = 1'b1;
      push_seg  = data_seg(best_e);
      push_last = rtx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != S_DEC) begin
      we <= 1'b0;
    end
    if (rst) begin
      state <= S_IDLE;
      conn  <= ST_CLOSED;
      nss   <= SEQ_BITS'(1);
      ers   <= SEQ_BITS'(1);
      ackp  <= 1'b0;
      ctl   <= '0;
      tss   <= '0;
      vld   <= '0;
      on    <= '0;
      oi    <= '0;
      ridx  <= '0;
      rd_ok <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd <= cmd; c_src <= src_node; c_dst <= dst_node;
            c_syn <= pkt_syn; c_ack <= pkt_ack; c_fin <= pkt_fin;
            c_bad <= pkt_corrupted; c_seq <= pkt_seq; c_pay <= payload;
            if (cmd == CMD_TICK) key <= nss_m1;
            else if (cmd == CMD_SEND) key <= nss;
            else key <= pkt_seq - 1'b1;
            hit_f <= 1'b0;
            ridx  <= '0;
            rd_ok <= 1'b0;
            sidx  <= '0;
            state <= S_SCAN;
          end
        end
        // one entry read per cycle, compare on registered data
        S_SCAN: begin
          if (rd_ok && vld[sidx] && rdata.seq == key && !hit_f) begin
            hit_f <= 1'b1; hit_i <= sidx; hit_e <= rdata;
          end
          sidx  <= ridx;
          rd_ok <= 1'b1;
          if (rd_ok && sidx == IDX_BITS'(STORE_DEPTH - 1)) begin
            state <= S_DEC;
          end else if (ridx != IDX_BITS'(STORE_DEPTH - 1)) begin
            ridx <= ridx + 1'b1;
          end
        end
        S_DEC: begin
          logic [2:0]          cs;
          logic [1:0]          n;
          logic                rtx;
          logic                hf;
          logic [15:0]         tn;
          logic                wr;
          seg_t                aseg;
          cs   = conn;
          n    = 2'd0;
          rtx  = 1'b0;
          tn   = tss;
          wr   = 1'b0;
          aseg = '0;
          hf   = hit_f || (rd_ok && vld[sidx] && rdata.seq == key);
          if (!hit_f && hf) begin hit_i <= sidx; hit_e <= rdata; end
          case (c_cmd)
            CMD_TICK: begin
              tn = tss_inc;
              if (tss_inc > timeout_ticks) begin
                if (ackp) begin
                  if (hf) begin
                    ob[0] <= data_seg(hit_f ? hit_e : rdata);
                    n = 2'd1;
                    tn = '0;
                  end
                end else if (conn == ST_SYN_SENT || conn == ST_SYN_RCVD ||
                             conn == ST_FIN_WAIT1 || conn == ST_CLOSE_ACK) begin
                  ob[0] <= ctl_seg(ctl[18:11], ctl[10:3], ctl[2], ctl[1], ctl[0]);
                  n = 2'd1;
                  tn = '0;
                end
              end
            end
            CMD_RECV: begin
              if (conn == ST_CLOSED) begin
                if (c_fin) begin
                  ob[0] <= ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0);
                  n = 2'd1;
                end
              end else if (c_syn && !c_ack &&
                           (conn == ST_LISTEN || conn == ST_SYN_RCVD)) begin
                cs = ST_SYN_RCVD;
                ctl <= {c_dst, c_src, 3'b110}; tn = '0;
                ob[0] <= ctl_seg(c_dst, c_src, 1'b1, 1'b1, 1'b0); n = 2'd1;
              end else if (c_syn && c_ack &&
                           (conn == ST_SYN_SENT || conn == ST_ESTAB)) begin
                cs = ST_ESTAB;
                ctl <= {c_dst, c_src, 3'b010}; tn = '0;
                ob[0] <= ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0); n = 2'd1;
              end else if (c_ack && !c_syn && conn == ST_SYN_RCVD) begin
                cs = ST_ESTAB;
              end else if (c_fin && !c_ack && conn == ST_ESTAB) begin
                cs = ST_CLOSE_ACK;
                ctl <= {c_dst, c_src, 3'b001}; tn = '0;
                ob[0] <= ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0);
                ob[1] <= ctl_seg(c_dst, c_src, 1'b0, 1'b0, 1'b1);
                n = 2'd2;
              end else if (c_fin && !c_ack && conn == ST_FIN_WAIT1) begin
                cs = ST_CLOSED;
                ctl <= {c_dst, c_src, 3'b010}; tn = '0;
                ob[0] <= ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0); n = 2'd1;
              end else if (c_ack && !c_fin && conn == ST_FIN_WAIT1) begin
                cs = ST_FIN_WAIT2;
              end else if (c_fin && conn == ST_FIN_WAIT2) begin
                cs = ST_CLOSED;
                ctl <= {c_dst, c_src, 3'b010}; tn = '0;
                ob[0] <= ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0); n = 2'd1;
              end else if (c_ack && conn == ST_CLOSE_ACK) begin
                cs = ST_CLOSED;
              end else if (c_ack && !c_syn && conn == ST_ESTAB) begin
                if (hf) vld[hit_f ? hit_i : sidx] <= 1'b0;
                ackp <= 1'b0;
              end else if (conn == ST_ESTAB && !c_bad) begin
                if (c_seq < ers) begin
                  aseg = ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0);
                  aseg.seq = ers;
                  ob[0] <= aseg; n = 2'd1;
                end else if (c_seq == ers) begin
                  ers <= ers + 1'b1;
                  aseg = ctl_seg(c_dst, c_src, 1'b0, 1'b1, 1'b0);
                  aseg.seq = ers + 1'b1;
                  ob[0] <= aseg; n = 2'd1;
                end else begin
                  rtx = 1'b1;
                end
              end
            end
            CMD_LISTN: if (conn == ST_CLOSED) cs = ST_LISTEN;
            CMD_CONN: begin
              if (conn == ST_CLOSED) begin
                cs = ST_SYN_SENT;
                ctl <= {c_src, c_dst, 3'b100}; tn = '0;
                ob[0] <= ctl_seg(c_src, c_dst, 1'b1, 1'b0, 1'b0); n = 2'd1;
              end
            end
            CMD_SEND: begin
              if (conn == ST_ESTAB || conn == ST_CLOSED) begin
                if (conn == ST_CLOSED) begin
                  cs = ST_SYN_SENT;
                  ctl <= {c_src, c_dst, 3'b100}; tn = '0;
                  ob[0] <= ctl_seg(c_src, c_dst, 1'b1, 1'b0, 1'b0); n = 2'd1;
                end
                if (!ackp && (hf || free_f)) begin
                  if (!hf) begin
                    vld[free_i] <= 1'b1;
                    wr = 1'b1;
                    waddr <= free_i;
                    wdata <= '{seq: nss, route: {c_src, c_dst}, data: c_pay};
                  end
                  ackp <= 1'b1; tn = '0;
                  ob[n] <= '{src: c_src, dst: c_dst, syn: 1'b0, ack: 1'b0,
                             fin: 1'b0, seq: nss, data: c_pay};
                  n = n + 2'd1;
                  nss <= nss + 1'b1;
                end
              end
            end
            CMD_DISC: begin
              if (conn == ST_ESTAB || conn == ST_CLOSE_ACK) begin
                cs = ST_FIN_WAIT1;
                ctl <= {c_src, c_dst, 3'b001}; tn = '0;
                ob[0] <= ctl_seg(c_src, c_dst, 1'b0, 1'b0, 1'b1); n = 2'd1;
              end
            end
            default: ;
          endcase
          we   <= wr;
          tss  <= tn;
          conn <= cs;
          on   <= n;
          oi   <= '0;
          if (rtx) begin
            first <= 1'b1; npass <= '0;
            best_f <= 1'b0; ridx <= '0; rd_ok <= 1'b0; sidx <= '0;
            state <= S_RTX;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (on == 2'd0) begin
            state <= S_IDLE;
          end else if (!q_full) begin
            oi <= oi + 1'b1;
            if (oi == on - 2'd1) state <= S_IDLE;
          end
        end
        // one min-search pass over the store per emitted segment
        S_RTX: begin
          if (cand) begin
            best_f <= 1'b1; best_e <= rdata;
          end
          sidx  <= ridx;
          rd_ok <= 1'b1;
          if (rd_ok && sidx == IDX_BITS'(STORE_DEPTH - 1)) begin
            if (best_f || cand) begin
              state <= S_RTXE;
            end else begin
              state <= S_IDLE;
            end
          end else if (ridx != IDX_BITS'(STORE_DEPTH - 1)) begin
            ridx <= ridx + 1'b1;
          end
        end
        S_RTXE: begin
          if (!q_full) begin
            if (rtx_last) begin
              state <= S_IDLE;
            end else begin
              first  <= 1'b0;
              prev   <= best_e.seq;
              npass  <= npass + 1'b1;
              best_f <= 1'b0; ridx <= '0; rd_ok <= 1'b0; sidx <= '0;
              state  <= S_RTX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/tcp_connection_stop_and_wait.sv
// ----------------------------------------------------------------------------
// tcp_connection_stop_and_wait
// One endpoint of a simplified TCP with stop-and-wait data transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   tick, received segment, listen, connect, send, disconnect.
//   Output channel (out_valid / out_stall) carries the segments each command
//   causes; 'last' marks the final one. Commands that cause nothing give no
//   output transfer.
//   timeout_ticks is written over cfg_valid / cfg_ready; the user must
//   write it only while idle, which the block itself does not enforce.
//   Every item is accepted, the retransmit store RAM is then scanned at
//   one entry per cycle, and the item is then decoded; each segment it
//   emits is then pushed to the output. An out-of-order data receipt runs
//   a min-search pass over the store for each resent segment.
//   Items are processed one at a time.
// Reset: synchronous, clears connection state, counters and store valid
//   bits; timeout_ticks returns to 500.
// Stall: a stalled output holds; the sequencer waits and then the input
//   channel stalls.
// ----------------------------------------------------------------------------
module tcp_connection_stop_and_wait
  import tcpsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [7:0]           src_node,
  input  logic [7:0]           dst_node,
  input  logic                 pkt_syn,
  input  logic                 pkt_ack,
  input  logic                 pkt_fin,
  input  logic                 pkt_corrupted,
  input  logic [SEQ_BITS-1:0]  pkt_seq,
  input  logic [DATA_BITS-1:0] payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_src,
  output logic [7:0]           out_dst,
  output logic                 out_syn,
  output logic                 out_ack,
  output logic                 out_fin,
  output logic [SEQ_BITS-1:0]  out_seq,
  output logic [DATA_BITS-1:0] out_payload,
  output logic [2:0]           conn_status,
  output logic                 awaiting_ack,
  output logic                 last
);
  logic [15:0] timeout_ticks;
  logic        push, q_full, p_await, p_last;
  seg_t        p_seg, o_seg;
  logic [2:0]  p_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  tcpsw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .timeout_ticks(timeout_ticks),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .src_node(src_node), .dst_node(dst_node), .pkt_syn(pkt_syn),
    .pkt_ack(pkt_ack), .pkt_fin(pkt_fin), .pkt_corrupted(pkt_corrupted),
    .pkt_seq(pkt_seq), .payload(payload),
    .push(push), .push_seg(p_seg), .push_status(p_status),
    .push_await(p_await), .push_last(p_last), .q_full(q_full)
  );

  tcpsw_outq u_outq (
    .clk(clk), .rst(rst), .push(push), .push_seg(p_seg),
    .push_status(p_status), .push_await(p_await), .push_last(p_last),
    .full(q_full), .out_valid(out_valid), .out_stall(out_stall),
    .out_seg(o_seg), .out_status(conn_status), .out_await(awaiting_ack),
    .out_last(last)
  );

  assign out_src     = o_seg.src;
  assign out_dst     = o_seg.dst;
  assign out_syn     = o_seg.syn;
  assign out_ack     = o_seg.ack;
  assign out_fin     = o_seg.fin;
  assign out_seq     = o_seg.seq;
  assign out_payload = o_seg.data;
endmodule

FILE: dv/tcp_connection_stop_and_wait_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_connection_stop_and_wait_test
// Self-checking bench for the stop-and-wait TCP endpoint. A directed table
// walks the handshake, data, teardown and corner cases; a state-aware random
// part then drives mostly legal traffic plus noise over several timeout
// settings. A local connection model predicts segments; typed table rows give their own.
// ----------------------------------------------------------------------------
module tcp_connection_stop_and_wait_test;
  import tcpsw_pkg::*;

  localparam logic [2:0] CMD_RSV6 = 3'd6;
  localparam logic [2:0] CMD_RSV7 = 3'd7;
  localparam int SETTLE_CYCLES = 64;   // covers the store scan plus a retransmit burst
  localparam int RAND_PER_PHASE = 76;

  // one command as driven on the input channel
  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic        syn;
    logic        ack;
    logic        fin;
    logic        bad;
    logic [15:0] seq;
    logic [31:0] data;
  } cmd_item_t;

  // one segment as seen on the output channel
  typedef struct {
    logic [7:0]  src;
    logic [7:0]  dst;
    logic        syn;
    logic        ack;
    logic        fin;
    logic [15:0] seq;
    logic [31:0] data;
    logic [2:0]  status;
    logic        waiting;
    logic        lst;
  } segment_t;

  // directed table row: how the expectation is formed
  typedef enum int {ROW_MODEL, ROW_TYPED_ONE, ROW_TYPED_NONE} row_kind_t;

  typedef struct {
    cmd_item_t item;
    row_kind_t kind;
    segment_t  seg;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_src, out_dst;
  logic out_syn, out_ack, out_fin;
  logic [SEQ_BITS-1:0] out_seq;
  logic [DATA_BITS-1:0] out_payload;
  logic [2:0] conn_status;
  logic awaiting_ack, last;

  cmd_item_t cur = '{cmd: CMD_TICK, default: '0};

  tcp_connection_stop_and_wait u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cur.cmd), .src_node(cur.src), .dst_node(cur.dst),
    .pkt_syn(cur.syn), .pkt_ack(cur.ack), .pkt_fin(cur.fin),
    .pkt_corrupted(cur.bad), .pkt_seq(cur.seq), .payload(cur.data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_src(out_src), .out_dst(out_dst), .out_syn(out_syn), .out_ack(out_ack),
    .out_fin(out_fin), .out_seq(out_seq), .out_payload(out_payload),
    .conn_status(conn_status), .awaiting_ack(awaiting_ack), .last(last)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Connection model
  // --------------------------------------------------------------------------
  logic [15:0] m_timeout;
  logic [2:0]  m_state;
  logic [15:0] m_snd_seq, m_rcv_seq;
  logic        m_waiting;
  logic [18:0] m_ctl;      // {src, dst, syn, ack, fin} of last control segment
  int unsigned m_ticks;
  bit          rt_valid [STORE_DEPTH];
  logic [15:0] rt_seq   [STORE_DEPTH];
  logic [15:0] rt_route [STORE_DEPTH];
  logic [31:0] rt_data  [STORE_DEPTH];
  seg_t        burst[$];   // segments of the current command

  segment_t segment_q[$];  // segments still owed by the block
  int fail_cnt = 0;
  int seg_cnt = 0;
  int item_cnt = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  bit stall_enable = 1'b0;

  function automatic void model_reset();
    m_timeout = TIMEOUT_RESET;
    m_state = ST_CLOSED;
    m_snd_seq = 16'd1;
    m_rcv_seq = 16'd1;
    m_waiting = 1'b0;
    m_ctl = '0;
    m_ticks = 0;
    foreach (rt_valid[i]) rt_valid[i] = 1'b0;
  endfunction

  function automatic void put_seg(logic [7:0] s, logic [7:0] d, logic sy, logic ak, logic fn,
                                  logic [15:0] sq, logic [31:0] dt);
    seg_t g;
    if (burst.size() >= 8) return;
    g = '{src: s, dst: d, syn: sy, ack: ak, fin: fn, seq: sq, data: dt};
    burst.push_back(g);
  endfunction

  function automatic void put_ctl(logic [7:0] s, logic [7:0] d, logic sy, logic ak, logic fn);
    m_ctl = {s, d, sy, ak, fn};
    m_ticks = 0;
    put_seg(s, d, sy, ak, fn, '0, '0);
  endfunction

  function automatic void put_stored(int i);
    put_seg(rt_route[i][15:8], rt_route[i][7:0], 1'b0, 1'b0, 1'b0, rt_seq[i], rt_data[i]);
  endfunction

  function automatic int lookup(logic [15:0] sq);
    for (int i = 0; i < STORE_DEPTH; i++)
      if (rt_valid[i] && rt_seq[i] == sq) return i;
    return -1;
  endfunction

  function automatic void start_fin(logic [7:0] s, logic [7:0] d, logic [2:0] nxt);
    if (m_state != ST_ESTAB && m_state != ST_CLOSE_ACK) return;
    m_state = nxt;
    put_ctl(s, d, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void send_data(logic [7:0] s, logic [7:0] d, logic [31:0] dt);
    int hit, slot;
    logic [15:0] sq;
    if (m_state != ST_ESTAB) begin
      if (m_state != ST_CLOSED) return;
      m_state = ST_SYN_SENT;
      put_ctl(s, d, 1'b1, 1'b0, 1'b0);
    end
    if (m_waiting) return;
    sq = m_snd_seq;
    hit = lookup(sq);
    if (hit < 0) begin
      slot = -1;
      for (int i = 0; i < STORE_DEPTH; i++)
        if (!rt_valid[i] && slot < 0) slot = i;
      if (slot < 0) return;   // store full: dropped
      rt_valid[slot] = 1'b1;
      rt_seq[slot] = sq;
      rt_route[slot] = {s, d};
      rt_data[slot] = dt;
    end
    m_waiting = 1'b1;
    m_ticks = 0;
    put_seg(s, d, 1'b0, 1'b0, 1'b0, sq, dt);
    m_snd_seq = m_snd_seq + 16'd1;
  endfunction

  // out-of-order receipt: resend stored segments, ascending sequence
  function automatic void resend_all();
    logic [15:0] prev;
    bit first;
    int best;
    prev = '0;
    first = 1'b1;
    for (int p = 0; p < STORE_DEPTH; p++) begin
      best = -1;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (rt_valid[i] && (first || rt_seq[i] > prev))
          if (best < 0 || rt_seq[i] < rt_seq[best]) best = i;
      end
      if (best < 0) break;
      put_stored(best);
      prev = rt_seq[best];
      first = 1'b0;
    end
  endfunction

  function automatic void take_segment(cmd_item_t it);
    int i;
    logic [7:0] s, d;
    s = it.src;
    d = it.dst;
    if (m_state == ST_CLOSED) begin
      if (it.fin) put_seg(d, s, 1'b0, 1'b1, 1'b0, '0, '0);
    end else if (it.syn && !it.ack && (m_state == ST_LISTEN || m_state == ST_SYN_RCVD)) begin
      m_state = ST_SYN_RCVD;
      put_ctl(d, s, 1'b1, 1'b1, 1'b0);
    end else if (it.syn && it.ack && (m_state == ST_SYN_SENT || m_state == ST_ESTAB)) begin
      put_ctl(d, s, 1'b0, 1'b1, 1'b0);
      m_state = ST_ESTAB;
    end else if (it.ack && !it.syn && m_state == ST_SYN_RCVD) begin
      m_state = ST_ESTAB;
    end else if (it.fin && !it.ack && m_state == ST_ESTAB) begin
      put_ctl(d, s, 1'b0, 1'b1, 1'b0);
      m_state = ST_CLOSE_ACK;
      start_fin(d, s, ST_CLOSE_ACK);
    end else if (it.fin && !it.ack && m_state == ST_FIN_WAIT1) begin
      m_state = ST_CLOSED;
      put_ctl(d, s, 1'b0, 1'b1, 1'b0);
    end else if (it.ack && !it.fin && m_state == ST_FIN_WAIT1) begin
      m_state = ST_FIN_WAIT2;
    end else if (it.fin && m_state == ST_FIN_WAIT2) begin
      m_state = ST_CLOSED;
      put_ctl(d, s, 1'b0, 1'b1, 1'b0);
    end else if (it.ack && m_state == ST_CLOSE_ACK) begin
      m_state = ST_CLOSED;
    end else if (it.ack && !it.syn && m_state == ST_ESTAB) begin
      i = lookup(it.seq - 16'd1);
      if (i >= 0) rt_valid[i] = 1'b0;
      m_waiting = 1'b0;
    end else if (m_state == ST_ESTAB && !it.bad) begin
      if (it.seq < m_rcv_seq) begin
        put_seg(d, s, 1'b0, 1'b1, 1'b0, m_rcv_seq, '0);
      end else if (it.seq == m_rcv_seq) begin
        m_rcv_seq = m_rcv_seq + 16'd1;
        put_seg(d, s, 1'b0, 1'b1, 1'b0, m_rcv_seq, '0);
      end else begin
        resend_all();
      end
    end
  endfunction

  function automatic void take_tick();
    int i;
    if (m_ticks < 32'hFFFF) m_ticks++;
    if (m_ticks <= m_timeout) return;
    if (m_waiting) begin
      i = lookup(m_snd_seq - 16'd1);
      if (i >= 0) begin
        put_stored(i);
        m_ticks = 0;
      end
    end else if (m_state == ST_SYN_SENT || m_state == ST_SYN_RCVD ||
                 m_state == ST_FIN_WAIT1 || m_state == ST_CLOSE_ACK) begin
      put_seg(m_ctl[18:11], m_ctl[10:3], m_ctl[2], m_ctl[1], m_ctl[0], '0, '0);
      m_ticks = 0;
    end
  endfunction

  // advance the model by one command and queue the segments it causes
  function automatic void predict_segments(cmd_item_t it, bit queue_them);
    segment_t e;
    burst.delete();
    case (it.cmd)
      CMD_TICK:  take_tick();
      CMD_RECV:  take_segment(it);
      CMD_LISTN: if (m_state == ST_CLOSED) m_state = ST_LISTEN;
      CMD_CONN: begin
        if (m_state == ST_CLOSED) begin
          m_state = ST_SYN_SENT;
          put_ctl(it.src, it.dst, 1'b1, 1'b0, 1'b0);
        end
      end
      CMD_SEND:  send_data(it.src, it.dst, it.data);
      CMD_DISC:  start_fin(it.src, it.dst, ST_FIN_WAIT1);
      default: ;
    endcase
    if (!queue_them) return;
    foreach (burst[k]) begin
      e = '{src: burst[k].src, dst: burst[k].dst, syn: burst[k].syn, ack: burst[k].ack,
            fin: burst[k].fin, seq: burst[k].seq, data: burst[k].data, status: m_state,
            waiting: m_waiting, lst: (k == burst.size() - 1)};
      segment_q.push_back(e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: input acceptance, config writes, output checking
  // --------------------------------------------------------------------------
  dir_row_t row_now;
  bit       row_active = 1'b0;

  function automatic void check_field(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    segment_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) m_timeout = cfg_data;
      if (in_valid && !in_stall) begin
        if (row_active && row_now.kind != ROW_MODEL) begin
          predict_segments(cur, 1'b0);
          if (row_now.kind == ROW_TYPED_ONE) segment_q.push_back(row_now.seg);
        end else begin
          predict_segments(cur, 1'b1);
        end
      end
      if (out_valid && !out_stall) begin
        seg_cnt++;
        if (segment_q.size() == 0) begin
          $display("%0t: segment with nothing expected, actual src %0h dst %0h seq %0h",
                   $time, out_src, out_dst, out_seq);
          fail_cnt++;
        end else begin
          e = segment_q.pop_front();
          check_field("out_src", 64'(e.src), 64'(out_src));
          check_field("out_dst", 64'(e.dst), 64'(out_dst));
          check_field("out_syn", 64'(e.syn), 64'(out_syn));
          check_field("out_ack", 64'(e.ack), 64'(out_ack));
          check_field("out_fin", 64'(e.fin), 64'(out_fin));
          check_field("out_seq", 64'(e.seq), 64'(out_seq));
          check_field("out_payload", 64'(e.data), 64'(out_payload));
          check_field("conn_status", 64'(e.status), 64'(conn_status));
          check_field("awaiting_ack", 64'(e.waiting), 64'(awaiting_ack));
          check_field("last", 64'(e.lst), 64'(last));
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk)
    out_stall <= stall_enable && ($urandom_range(0, 99) < rx_idle);

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic cmd_item_t mk(logic [2:0] c, logic [7:0] s, logic [7:0] d, logic sy,
                                   logic ak, logic fn, logic bd, logic [15:0] sq,
                                   logic [31:0] dt);
    cmd_item_t it;
    it = '{cmd: c, src: s, dst: d, syn: sy, ack: ak, fin: fn, bad: bd, seq: sq, data: dt};
    return it;
  endfunction

  // random command shaped by the model's current state
  function automatic cmd_item_t pick_item();
    cmd_item_t it;
    int r;
    it = mk(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1'($urandom),
            1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 15) return it;   // pure noise
    {it.syn, it.ack, it.fin} = '0;
    it.bad = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 99);
    if (r < 18) begin
      it.cmd = CMD_TICK;
      return it;
    end
    case (m_state)
      ST_CLOSED: begin
        if (r < 50) it.cmd = CMD_CONN;
        else if (r < 65) it.cmd = CMD_SEND;
        else if (r < 90) it.cmd = CMD_LISTN;
        else begin
          it.cmd = CMD_RECV;
          it.fin = 1'b1;
        end
      end
      ST_LISTEN: begin
        it.cmd = CMD_RECV;
        it.syn = 1'b1;
      end
      ST_SYN_SENT: begin
        it.cmd = CMD_RECV;
        {it.syn, it.ack} = 2'b11;
      end
      ST_SYN_RCVD: begin
        it.cmd = CMD_RECV;
        it.ack = 1'b1;
        it.syn = (r < 30);
      end
      ST_ESTAB: begin
        it.cmd = CMD_RECV;
        if (r < 45) it.cmd = CMD_SEND;
        else if (r < 62) begin
          it.ack = 1'b1;
          it.seq = ($urandom_range(0, 4) == 0) ? it.seq : m_snd_seq;
        end else if (r < 78) it.seq = m_rcv_seq;
        else if (r < 83) it.seq = m_rcv_seq - 16'($urandom_range(1, 3));
        else if (r < 90) it.seq = m_rcv_seq + 16'($urandom_range(1, 5));
        else if (r < 93) {it.syn, it.ack} = 2'b11;
        else if (r < 97) it.cmd = CMD_DISC;
        else it.fin = 1'b1;
      end
      ST_FIN_WAIT1: begin
        it.cmd = CMD_RECV;
        if (r < 60) it.ack = 1'b1;
        else it.fin = 1'b1;
      end
      ST_FIN_WAIT2: begin
        it.cmd = CMD_RECV;
        it.fin = 1'b1;
        it.ack = (r < 40);
      end
      default: begin   // waiting for the ACK of our FIN after a peer close
        it.cmd = (r < 30) ? CMD_DISC : CMD_RECV;
        it.ack = 1'b1;
      end
    endcase
    return it;
  endfunction

  // one input transfer; called just after a falling edge, returns after one
  task automatic drive_item(cmd_item_t it);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    item_cnt++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (segment_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  dir_row_t dir_rows[$];
  logic [15:0] timeout_plan[6] = '{16'd1, 16'd65535, 16'd2, 16'd500, 16'd5, 16'd1};

  function automatic void add_row(cmd_item_t it, row_kind_t k, segment_t s);
    dir_row_t r;
    r = '{item: it, kind: k, seg: s};
    dir_rows.push_back(r);
  endfunction

  initial begin
    segment_t none;
    segment_t s;
    int rnd;
    none = '{default: '0};
    model_reset();

    // closed endpoint answers a FIN with a bare ACK back to the sender
    s = '{src: 8'h34, dst: 8'h12, syn: 1'b0, ack: 1'b1, fin: 1'b0, seq: '0, data: '0,
          status: ST_CLOSED, waiting: 1'b0, lst: 1'b1};
    add_row(mk(CMD_RECV, 8'h12, 8'h34, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0, 32'h0),
            ROW_TYPED_ONE, s);
    add_row(mk(CMD_RSV6, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 32'hFFFFFFFF),
            ROW_TYPED_NONE, none);
    add_row(mk(CMD_RSV7, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_TYPED_NONE, none);
    add_row(mk(CMD_DISC, 8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_TYPED_NONE, none);
    add_row(mk(CMD_LISTN, 8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_CONN, 8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h05, 8'h0A, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h05, 8'h0A, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h05, 8'h0A, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_LISTN, 8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_SEND, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'hFFFFFFFF),
            ROW_MODEL, none);
    // send while a data transfer is outstanding is dropped
    add_row(mk(CMD_SEND, 8'h11, 8'h22, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h12345678),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 16'h2, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_SEND, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h0A, 8'h05, 1'b0, 1'b0, 1'b0, 1'b0, 16'h1, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h0A, 8'h05, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h0A, 8'h05, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 32'h0),
            ROW_MODEL, none);
    // out-of-order receipt: burst of stored segments
    add_row(mk(CMD_RECV, 8'h0A, 8'h05, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'h0A, 8'h05, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_SEND, 8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'hA5A5A5A5),
            ROW_MODEL, none);
    add_row(mk(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_DISC, 8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'hA5, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    add_row(mk(CMD_RECV, 8'hA5, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0, 32'h0),
            ROW_MODEL, none);
    // send while closed opens the handshake first
    add_row(mk(CMD_SEND, 8'h33, 8'h44, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0, 32'hC0FFEE00),
            ROW_MODEL, none);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    stall_enable = 1'b1;

    row_active = 1'b1;
    foreach (dir_rows[i]) begin
      row_now = dir_rows[i];
      drive_item(dir_rows[i].item);
    end
    wait_drained();
    row_active = 1'b0;

    // random part, one timeout setting per phase, idle profile by progress
    rnd = 0;
    foreach (timeout_plan[ph]) begin
      write_timeout(timeout_plan[ph]);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (rnd < 150) begin
          tx_idle = 15;
          rx_idle = 50;
        end else if (rnd < 300) begin
          tx_idle = 50;
          rx_idle = 15;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        if (rnd == 200) wait_drained();   // sender holds off until all segments are out
        drive_item(pick_item());
        rnd++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (segment_q.size() != 0) begin
      $display("%0t: %0d segments never arrived", $time, segment_q.size());
      fail_cnt++;
    end
    $display("Covered %0d commands and %0d checked segments over %0d timeout settings,",
             item_cnt, seg_cnt, $size(timeout_plan));
    $display("including handshakes, data, teardown, retransmit bursts and timeouts.");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
